// ----- rtl/tdsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tdsm_pkg
// Shared types and codes for the table-driven state machine.
// ----------------------------------------------------------------------------
package tdsm_pkg;

    // Table from-states are held at full width so wide state counts and
    // initial states are kept exactly; events and to-states are 3 bits.
    localparam int STATE_W = 6;
    localparam int CODE_W  = 3;

    typedef enum logic [1:0] {
        OP_DISPATCH = 2'd0,
        OP_ADD      = 2'd1,
        OP_FILL     = 2'd2
    } op_t;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;
    localparam logic [1:0] STATUS_GUARD    = 2'd3;

    localparam logic CFG_FAULT_STATE = 1'b0;
    localparam logic CFG_ERROR_EVENT = 1'b1;

    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [CODE_W-1:0]  evt;
        logic [CODE_W-1:0]  to_state;
    } entry_t;

    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [CODE_W-1:0]  evt;
    } key_t;

endpackage

// ----- rtl/tdsm_table.sv -----
// ----------------------------------------------------------------------------
// tdsm_table
// Transition table memory with a registered read port and the single
// entry comparator used by every search.
// ----------------------------------------------------------------------------
module tdsm_table
    import tdsm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  entry_t             wr_entry,
    input  logic [AW-1:0]      rd_addr,
    input  key_t               key,
    output logic               hit,
    output logic [CODE_W-1:0]  hit_target
);

    entry_t mem [DEPTH];
    entry_t rd_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_q <= mem[rd_addr];
    end

    assign hit        = (rd_q.from_state == key.from_state) && (rd_q.evt == key.evt);
    assign hit_target = rd_q.to_state;

endmodule

// ----- rtl/table_driven_state_machine_top.sv -----
// ----------------------------------------------------------------------------
// table_driven_state_machine_top
// Dispatch: entries are compared in insertion order and the first match
//   is taken; one comparator on the table read port.
// Add: appends at the next free slot. Error-fill: adds missing error-event rows.
// One item at a time; the next item is taken once the result is registered.
// Reset: table empty, current state INITIAL_STATE, fault state and error
//   event 7; table contents are undefined but never read before written.
// ----------------------------------------------------------------------------
module table_driven_state_machine_top
    import tdsm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int STATE_COUNT   = 8,
    parameter int INITIAL_STATE = 0
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [2:0]  source_state,
    input  logic [2:0]  event_code,
    input  logic [2:0]  target_state,
    input  logic        guard_pass,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [1:0]  status,
    output logic [2:0]  previous_state,
    output logic [2:0]  present_state,
    output logic [5:0]  entry_count
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW    = $clog2(STATE_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FILL_SEL,
        S_FILL_SCAN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     idx_next;
    logic [CNT_W-1:0]     used_reg;
    logic [STATE_W-1:0]   cur_reg;
    logic [STATE_W-1:0]   prev_reg;
    logic [CODE_W-1:0]    fault_reg;
    logic [CODE_W-1:0]    err_evt_reg;
    logic [SW-1:0]        s_reg;
    logic [CODE_W-1:0]    evt_reg;
    logic                 guard_reg;
    logic                 res_ok_reg;
    logic [1:0]           res_status_reg;

    logic                 out_valid_reg;
    logic                 ok_reg;
    logic [1:0]           status_reg;
    logic [2:0]           previous_state_reg;
    logic [2:0]           present_state_reg;
    logic [5:0]           entry_count_reg;

    logic                 full;
    logic                 scan_end;
    logic [STATE_W-1:0]   fill_state;
    logic                 wr_en;
    entry_t               wr_entry;
    key_t                 key;
    logic                 hit;
    logic [CODE_W-1:0]    hit_target;

    assign full       = used_reg >= CNT_W'(TABLE_ENTRIES);
    assign scan_end   = idx_reg >= used_reg;
    assign fill_state = STATE_W'(s_reg);
    assign in_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_entry = '{from_state: STATE_W'(source_state), evt: event_code,
                     to_state: target_state};
        key      = '{from_state: cur_reg, evt: evt_reg};
        unique case (state_reg)
            S_IDLE:
            begin
                wr_en = in_valid && (op_t'(operation) == OP_ADD) && !full;
            end
            S_FILL_SEL, S_FILL_SCAN:
            begin
                wr_en    = (state_reg == S_FILL_SCAN) && scan_end && !full;
                wr_entry = '{from_state: fill_state, evt: err_evt_reg,
                             to_state: fault_reg};
                key      = '{from_state: fill_state, evt: err_evt_reg};
            end
            default:
            begin
            end
        endcase
    end

    // Read address runs one step ahead so the registered read lines up with idx_reg.
    always_comb
    begin
        unique case (state_reg)
            S_SCAN, S_FILL_SCAN: idx_next = idx_reg + CNT_W'(1);
            default:             idx_next = '0;
        endcase
    end

    tdsm_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .clk        (clk),
        .wr_en      (wr_en),
        .wr_addr    (used_reg[AW-1:0]),
        .wr_entry   (wr_entry),
        .rd_addr    (idx_next[AW-1:0]),
        .key        (key),
        .hit        (hit),
        .hit_target (hit_target)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            idx_reg            <= '0;
            used_reg           <= '0;
            cur_reg            <= STATE_W'(INITIAL_STATE);
            prev_reg           <= '0;
            fault_reg          <= 3'd7;
            err_evt_reg        <= 3'd7;
            s_reg              <= '0;
            evt_reg            <= '0;
            guard_reg          <= 1'b0;
            res_ok_reg         <= 1'b0;
            res_status_reg     <= STATUS_DONE;
            out_valid_reg      <= 1'b0;
            ok_reg             <= 1'b0;
            status_reg         <= STATUS_DONE;
            previous_state_reg <= '0;
            present_state_reg  <= '0;
            entry_count_reg    <= '0;
        end
        else
        begin
            idx_reg <= idx_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_FAULT_STATE: fault_reg   <= cfg_data;
                    CFG_ERROR_EVENT: err_evt_reg <= cfg_data;
                endcase
            end

            // in S_FINISH the new result takes the slot being emptied
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        prev_reg       <= cur_reg;
                        evt_reg        <= event_code;
                        guard_reg      <= guard_pass;
                        res_ok_reg     <= 1'b0;
                        res_status_reg <= STATUS_DONE;
                        unique case (op_t'(operation))
                            OP_DISPATCH:
                            begin
                                state_reg <= S_SCAN;
                            end
                            OP_ADD:
                            begin
                                if (full)
                                begin
                                    res_status_reg <= STATUS_FULL;
                                end
                                else
                                begin
                                    used_reg   <= used_reg + CNT_W'(1);
                                    res_ok_reg <= 1'b1;
                                end
                                state_reg <= S_FINISH;
                            end
                            OP_FILL:
                            begin
                                s_reg      <= '0;
                                res_ok_reg <= 1'b1;
                                state_reg  <= S_FILL_SEL;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (scan_end)
                    begin
                        res_status_reg <= STATUS_NO_MATCH;
                        state_reg      <= S_FINISH;
                    end
                    else if (hit)
                    begin
                        if (guard_reg)
                        begin
                            cur_reg    <= STATE_W'(hit_target);
                            res_ok_reg <= 1'b1;
                        end
                        else
                        begin
                            res_status_reg <= STATUS_GUARD;
                        end
                        state_reg <= S_FINISH;
                    end
                end

                S_FILL_SEL:
                begin
                    if (s_reg == SW'(STATE_COUNT))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (fill_state == STATE_W'(fault_reg))
                    begin
                        s_reg <= s_reg + SW'(1);
                    end
                    else
                    begin
                        state_reg <= S_FILL_SCAN;
                    end
                end

                S_FILL_SCAN:
                begin
                    if (scan_end)
                    begin
                        if (full)
                        begin
                            // table ran out: keep what was added, report failure
                            res_ok_reg     <= 1'b0;
                            res_status_reg <= STATUS_FULL;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            used_reg  <= used_reg + CNT_W'(1);
                            s_reg     <= s_reg + SW'(1);
                            state_reg <= S_FILL_SEL;
                        end
                    end
                    else if (hit)
                    begin
                        s_reg     <= s_reg + SW'(1);
                        state_reg <= S_FILL_SEL;
                    end
                end

                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg      <= 1'b1;
                        ok_reg             <= res_ok_reg;
                        status_reg         <= res_status_reg;
                        previous_state_reg <= prev_reg[2:0];
                        present_state_reg  <= cur_reg[2:0];
                        entry_count_reg    <= 6'(used_reg);
                        state_reg          <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign status         = status_reg;
    assign previous_state = previous_state_reg;
    assign present_state  = present_state_reg;
    assign entry_count    = entry_count_reg;

endmodule

// ----- tb/tdsm_transition_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdsm_transition_checker
// Watches the config port and both channels of the table-driven state
// machine. Keeps its own copy of the transition table, current state and
// fault/error registers, predicts the outcome of every accepted item and
// compares it field by field with the results in order.
// ----------------------------------------------------------------------------
module tdsm_transition_checker
    import tdsm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 32,
    parameter int STATE_COUNT   = 8,
    parameter int INITIAL_STATE = 0
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [2:0]  source_state,
    input  logic [2:0]  event_code,
    input  logic [2:0]  target_state,
    input  logic        guard_pass,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        ok,
    input  logic [1:0]  status,
    input  logic [2:0]  previous_state,
    input  logic [2:0]  present_state,
    input  logic [5:0]  entry_count,

    output int          error_count,
    output int          pending
);

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
        logic [2:0] prev_state;
        logic [2:0] next_state;
        logic [5:0] count;
    } outcome_t;

    // from-states and the current state are kept at 6 bits so wide state
    // counts and initial states compare exactly
    logic [5:0] row_from [TABLE_ENTRIES];
    logic [2:0] row_evt  [TABLE_ENTRIES];
    logic [2:0] row_to   [TABLE_ENTRIES];
    int         rows_used;
    logic [5:0] machine_state;
    logic [2:0] fault_reg;
    logic [2:0] error_evt_reg;

    outcome_t   expected_outcomes [$];
    outcome_t   oldest;

    // first row in insertion order that matches, -1 if none
    function automatic int lookup_row(logic [5:0] from_st, logic [2:0] evt);
        for (int i = 0; i < rows_used; i++)
        begin
            if (row_from[i] == from_st && row_evt[i] == evt)
                return i;
        end
        return -1;
    endfunction

    function automatic bit append_row(logic [5:0] from_st, logic [2:0] evt,
                                      logic [2:0] to_st);
        if (rows_used >= TABLE_ENTRIES)
            return 1'b0;
        row_from[rows_used] = from_st;
        row_evt[rows_used]  = evt;
        row_to[rows_used]   = to_st;
        rows_used++;
        return 1'b1;
    endfunction

    function automatic outcome_t step_machine(logic [1:0] op, logic [2:0] src,
                                              logic [2:0] evt, logic [2:0] dst,
                                              logic grd);
        outcome_t   res;
        int         hit;
        logic [5:0] st;
        res            = '0;
        res.prev_state = machine_state[2:0];
        case (op)
            OP_DISPATCH:
            begin
                hit = lookup_row(machine_state, evt);
                if (hit < 0)
                    res.status = STATUS_NO_MATCH;
                else if (!grd)
                    res.status = STATUS_GUARD;
                else
                begin
                    machine_state = 6'(row_to[hit]);
                    res.ok        = 1'b1;
                end
            end
            OP_ADD:
            begin
                if (append_row(6'(src), evt, dst))
                    res.ok = 1'b1;
                else
                    res.status = STATUS_FULL;
            end
            OP_FILL:
            begin
                res.ok = 1'b1;
                for (int s = 0; s < STATE_COUNT; s++)
                begin
                    st = s[5:0];
                    if (st == 6'(fault_reg))
                        continue;
                    if (lookup_row(st, error_evt_reg) >= 0)
                        continue;
                    // stops at a full table, rows added so far stay
                    if (!append_row(st, error_evt_reg, fault_reg))
                    begin
                        res.ok     = 1'b0;
                        res.status = STATUS_FULL;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.next_state = machine_state[2:0];
        res.count      = rows_used[5:0];
        return res;
    endfunction

    task automatic check_field(string name, logic [5:0] want, logic [5:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used     = 0;
            machine_state = INITIAL_STATE[5:0];
            fault_reg     = 3'd7;
            error_evt_reg = 3'd7;
            expected_outcomes.delete();
            pending       = 0;
            error_count   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result transfer with no outcome pending");
                    error_count++;
                end
                else
                begin
                    oldest = expected_outcomes.pop_front();
                    check_field("ok", 6'(oldest.ok), 6'(ok));
                    check_field("status", 6'(oldest.status), 6'(status));
                    check_field("previous_state", 6'(oldest.prev_state),
                                6'(previous_state));
                    check_field("present_state", 6'(oldest.next_state),
                                6'(present_state));
                    check_field("entry_count", oldest.count, entry_count);
                end
            end
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_FAULT_STATE)
                    fault_reg = cfg_data;
                else
                    error_evt_reg = cfg_data;
            end
            if (in_valid && in_ready)
                expected_outcomes.push_back(step_machine(operation, source_state,
                                                         event_code, target_state,
                                                         guard_pass));
            pending = expected_outcomes.size();
        end
    end

endmodule

// ----- tb/table_driven_state_machine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_state_machine_top_tb
// Directed then random items for the table-driven state machine: entry adds,
// error-fills under several fault/error settings, dispatches biased toward
// low event codes so matches are frequent. Random gaps on both channels; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module table_driven_state_machine_top_tb;
    import tdsm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [2:0]  cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [2:0]  source_state = '0;
    logic [2:0]  event_code = '0;
    logic [2:0]  target_state = '0;
    logic        guard_pass = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        ok;
    logic [1:0]  status;
    logic [2:0]  previous_state;
    logic [2:0]  present_state;
    logic [5:0]  entry_count;

    int          error_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          steady_in = 1'b0;
    bit          steady_out = 1'b0;

    table_driven_state_machine_top dut (.*);

    tdsm_transition_checker tracker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ends the run if nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("table_driven_state_machine_top_tb: errors");
            $finish;
        end
    end

    // result side: random stall before each transfer, with no-stall stretches
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = steady_out ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 29) == 0)
                steady_out = !steady_out;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic push_item(input logic [1:0] op, input logic [2:0] src,
                             input logic [2:0] evt, input logic [2:0] dst,
                             input logic grd);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 29) == 0)
            steady_in = !steady_in;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation    <= op;
        source_state <= src;
        event_code   <= evt;
        target_state <= dst;
        guard_pass   <= grd;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // called at the step of the last transfer; returns at a rising edge
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [2:0] fault_st, input logic [2:0] err_evt,
                             input int count);
        int         pick;
        logic [1:0] op;
        logic [2:0] src;
        logic [2:0] evt;
        logic [2:0] dst;
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FAULT_STATE;
        cfg_data  <= fault_st;
        @(posedge clk);
        cfg_index <= CFG_ERROR_EVENT;
        cfg_data  <= err_evt;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                op = OP_DISPATCH;
            else if (pick < 84)
                op = OP_ADD;
            else if (pick < 90)
                op = OP_FILL;
            else if (pick < 93)
                op = OP_UNUSED;
            else
                op = 2'($urandom_range(0, 3));
            src = 3'($urandom_range(0, 7));
            dst = 3'($urandom_range(0, 7));
            // low events dominate so dispatches often find a row
            evt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(0, 3));
            push_item(op, src, evt, dst, $urandom_range(0, 7) != 0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unused code, duplicate keys, guard refusal
        push_item(OP_DISPATCH, 3'd0, 3'd0, 3'd0, 1'b1);
        push_item(OP_UNUSED,   3'd7, 3'd7, 3'd7, 1'b1);
        push_item(OP_ADD,      3'd0, 3'd0, 3'd7, 1'b1);
        push_item(OP_ADD,      3'd7, 3'd7, 3'd0, 1'b1);
        push_item(OP_ADD,      3'd0, 3'd0, 3'd3, 1'b1);
        push_item(OP_DISPATCH, 3'd0, 3'd0, 3'd0, 1'b0);
        push_item(OP_DISPATCH, 3'd0, 3'd0, 3'd0, 1'b1);
        push_item(OP_DISPATCH, 3'd0, 3'd7, 3'd0, 1'b1);
        push_item(OP_DISPATCH, 3'd0, 3'd5, 3'd0, 1'b1);
        // error-fill, then again with nothing left to add
        push_item(OP_FILL,     3'd0, 3'd0, 3'd0, 1'b0);
        push_item(OP_FILL,     3'd7, 3'd7, 3'd7, 1'b1);
        push_item(OP_DISPATCH, 3'd0, 3'd7, 3'd0, 1'b1);
        push_item(OP_ADD,      3'd7, 3'd3, 3'd5, 1'b0);
        push_item(OP_DISPATCH, 3'd0, 3'd3, 3'd0, 1'b1);
        push_item(OP_ADD,      3'd5, 3'd1, 3'd2, 1'b0);
        push_item(OP_UNUSED,   3'd0, 3'd0, 3'd0, 1'b0);

        // short early phases add fill rows fast so a fill runs into a full table
        run_phase(3'd0, 3'd0, 40);
        run_phase(3'd4, 3'd5, 40);
        run_phase(3'd6, 3'd2, 40);
        run_phase(3'd7, 3'd0, 300);
        run_phase(3'd0, 3'd7, 300);
        run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 350);

        drain();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("table_driven_state_machine_top_tb: clean");
        else
            $display("table_driven_state_machine_top_tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tdsm_pkg.sv
rtl/tdsm_table.sv
rtl/table_driven_state_machine_top.sv
tb/tdsm_transition_checker.sv
tb/table_driven_state_machine_top_tb.sv
